### design/lcal_pkg.sv
// Shared types, codes and constants of the lowest common ancestor engine.
`default_nettype none

package lcal_pkg;

  // Width of a node number and of a depth on the channels and in the memories.
  localparam int NODE_FW = 16;
  // Width of the level field in an ancestor memory request (enough for 20 levels).
  localparam int LVL_FW = 5;

  // Defaults for the top-level parameters.
  localparam int NODES_DEFAULT  = 65536;
  localparam int LEVELS_DEFAULT = 16;

  // The root is node one, its own parent, at depth zero.
  localparam logic [NODE_FW-1:0] ROOT_NODE  = 16'd1;
  localparam logic [NODE_FW-1:0] DEPTH_MAX  = 16'hFFFF;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_BD_RD1,
    S_BD_RD2,
    S_BD_WR,
    S_Q_RDA,
    S_Q_RDB,
    S_Q_CMP,
    S_Q_LIFT,
    S_Q_LIFTW,
    S_Q_EQ,
    S_Q2_RA,
    S_Q2_RB,
    S_Q2_UPD,
    S_Q_FIN,
    S_Q_RES,
    S_DONE
  } state_t;

  // One access to the ancestor memory: a read every cycle, a write when we is set.
  typedef struct packed {
    logic               we;
    logic [LVL_FW-1:0]  level;
    logic [NODE_FW-1:0] node;
    logic [NODE_FW-1:0] wdata;
  } anc_req_t;

  // One access to the depth memory.
  typedef struct packed {
    logic               we;
    logic [NODE_FW-1:0] node;
    logic [NODE_FW-1:0] wdata;
  } dep_req_t;

endpackage

`default_nettype wire

### design/lcal_cmd_if.sv
// Command channel: one item carries a command code and two node numbers.
`default_nettype none

interface lcal_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic [lcal_pkg::NODE_FW-1:0] node_a;
  logic [lcal_pkg::NODE_FW-1:0] node_b;

  modport source (output valid, output command, output node_a, output node_b, input ready);
  modport sink (input valid, input command, input node_a, input node_b, output ready);
endinterface

`default_nettype wire

### design/lcal_rsp_if.sv
// Result channel: one item carries the ancestor found by a query.
`default_nettype none

interface lcal_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lcal_pkg::NODE_FW-1:0] ancestor;

  modport source (output valid, output ancestor, input ready);
  modport sink (input valid, input ancestor, output ready);
endinterface

`default_nettype wire

### design/lcal_anc_mem.sv
// Ancestor table memory: one entry per level and node, registered read.
`default_nettype none

module lcal_anc_mem #(
  parameter int NODES  = lcal_pkg::NODES_DEFAULT,
  parameter int LEVELS = lcal_pkg::LEVELS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire lcal_pkg::anc_req_t           req,
  output logic [lcal_pkg::NODE_FW-1:0]      rdata
);
  import lcal_pkg::*;

  localparam int NODE_W = $clog2(NODES);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int DEPTH  = LEVELS * (2 ** NODE_W);

  logic [LVL_W+NODE_W-1:0] addr;
  logic [NODE_FW-1:0]      mem [DEPTH];
  logic [NODE_FW-1:0]      q;
  logic                    root_hit;

  // Level in the upper bits, node in the lower bits.
  assign addr = {req.level[LVL_W-1:0], NODE_W'(req.node)};

  // Single port: write when requested, read the same address every cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= req.wdata;
    end
    q <= mem[addr];
  end

  // Level zero of the root always reads as the root itself.
  always_ff @(posedge clk) begin
    root_hit <= (req.level == '0) && (req.node == ROOT_NODE);
  end

  assign rdata = root_hit ? ROOT_NODE : q;

endmodule

`default_nettype wire

### design/lcal_dep_mem.sv
// Node depth memory: one entry per node, registered read.
`default_nettype none

module lcal_dep_mem #(
  parameter int NODES = lcal_pkg::NODES_DEFAULT
) (
  input  wire logic                         clk,
  input  wire lcal_pkg::dep_req_t           req,
  output logic [lcal_pkg::NODE_FW-1:0]      rdata
);
  import lcal_pkg::*;

  localparam int NODE_W = $clog2(NODES);

  logic [NODE_W-1:0]  addr;
  logic [NODE_FW-1:0] mem [NODES];
  logic [NODE_FW-1:0] q;
  logic               root_hit;

  assign addr = NODE_W'(req.node);

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= req.wdata;
    end
    q <= mem[addr];
  end

  // The root is never written and always sits at depth zero.
  always_ff @(posedge clk) begin
    root_hit <= (req.node == ROOT_NODE);
  end

  assign rdata = root_hit ? '0 : q;

endmodule

`default_nettype wire

### design/lcal_ctrl.sv
// Sequencer for load, build and query commands over the two memories.
`default_nettype none

module lcal_ctrl #(
  parameter int NODES  = lcal_pkg::NODES_DEFAULT,
  parameter int LEVELS = lcal_pkg::LEVELS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [lcal_pkg::NODE_FW-1:0] node_count,
  lcal_cmd_if.sink                          cmd,
  lcal_rsp_if.source                        rsp,
  output lcal_pkg::anc_req_t                anc_req,
  input  wire logic [lcal_pkg::NODE_FW-1:0] anc_rdata,
  output lcal_pkg::dep_req_t                dep_req,
  input  wire logic [lcal_pkg::NODE_FW-1:0] dep_rdata
);
  import lcal_pkg::*;

  localparam int               LVL_W    = $clog2(LEVELS);
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

  state_t             state, state_next;
  logic [NODE_FW-1:0] a, a_next;
  logic [NODE_FW-1:0] b, b_next;
  logic [NODE_FW-1:0] pa, pa_next;
  logic [LVL_W-1:0]   lvl, lvl_next;
  logic [NODE_FW-1:0] j, j_next;
  logic [NODE_FW-1:0] last, last_next;
  logic [NODE_FW-1:0] da, da_next;
  logic [NODE_FW-1:0] diff, diff_next;
  logic [NODE_FW-1:0] result, result_next;
  logic               out_valid, out_valid_next;
  logic [NODE_FW-1:0] out_data, out_data_next;

  logic               ok_a, ok_b;
  logic [NODE_FW-1:0] last_in;
  logic [LVL_W-1:0]   lvl_dec;
  logic [31:0]        diff_sh;
  logic               diff_sat;
  logic               jump;
  logic               deep_enough;

  // Node range checks and the clamped end of the build sweep.
  assign ok_a    = (cmd.node_a != '0) && (32'(cmd.node_a) < NODES);
  assign ok_b    = (cmd.node_b != '0) && (32'(cmd.node_b) < NODES);
  assign last_in = (32'(node_count) >= NODES) ? NODE_FW'(NODES - 1) : node_count;

  // Per-level quantities: jump decision of the depth equalization and the depth test
  // of the joint walk, which uses the depth just read for the current node.
  assign lvl_dec     = lvl - LVL_ONE;
  assign diff_sh     = 32'(diff) >> lvl;
  assign diff_sat    = (32'(diff) >> LEVELS) != 32'd0;
  assign jump        = diff_sat || diff_sh[0];
  assign deep_enough = 32'(dep_rdata) >= (32'd1 << lvl);

  assign cmd.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.ancestor = out_data;

  // State register and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      lvl       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      lvl       <= lvl_next;
    end
    a         <= a_next;
    b         <= b_next;
    pa        <= pa_next;
    j         <= j_next;
    last      <= last_next;
    da        <= da_next;
    diff      <= diff_next;
    result    <= result_next;
    out_data  <= out_data_next;
  end

  // Next state, memory requests and register updates.
  always_comb begin
    state_next     = state;
    a_next         = a;
    b_next         = b;
    pa_next        = pa;
    lvl_next       = lvl;
    j_next         = j;
    last_next      = last;
    da_next        = da;
    diff_next      = diff;
    result_next    = result;
    out_valid_next = out_valid && !rsp.ready;
    out_data_next  = out_data;
    anc_req        = '0;
    dep_req        = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.command)
            CMD_LOAD: begin
              // The root keeps its own link; out-of-range nodes are dropped.
              if (ok_a && ok_b && (cmd.node_a != ROOT_NODE)) begin
                a_next     = cmd.node_a;
                b_next     = cmd.node_b;
                state_next = S_LD_RD;
              end
            end
            CMD_BUILD: begin
              if (last_in != '0) begin
                last_next  = last_in;
                lvl_next   = LVL_ONE;
                j_next     = NODE_FW'(1);
                state_next = S_BD_RD1;
              end
            end
            CMD_QUERY: begin
              a_next = cmd.node_a;
              b_next = cmd.node_b;
              if (ok_a && ok_b) begin
                state_next = S_Q_RDA;
              end else begin
                result_next = '0;
                state_next  = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      // Load: fetch the parent's depth, then write link and depth.
      S_LD_RD: begin
        dep_req.node = b;
        state_next   = S_LD_WR;
      end
      S_LD_WR: begin
        dep_req.we    = 1'b1;
        dep_req.node  = a;
        dep_req.wdata = (dep_rdata == DEPTH_MAX) ? DEPTH_MAX : dep_rdata + NODE_FW'(1);
        anc_req.we    = 1'b1;
        anc_req.level = '0;
        anc_req.node  = a;
        anc_req.wdata = b;
        state_next    = S_IDLE;
      end

      // Build: level lvl of j is level lvl-1 of its level lvl-1 ancestor.
      S_BD_RD1: begin
        anc_req.level = LVL_FW'(lvl_dec);
        anc_req.node  = j;
        state_next    = S_BD_RD2;
      end
      S_BD_RD2: begin
        anc_req.level = LVL_FW'(lvl_dec);
        anc_req.node  = anc_rdata;
        state_next    = S_BD_WR;
      end
      S_BD_WR: begin
        anc_req.we    = 1'b1;
        anc_req.level = LVL_FW'(lvl);
        anc_req.node  = j;
        anc_req.wdata = anc_rdata;
        if (j == last) begin
          if (lvl == LVL_LAST) begin
            state_next = S_IDLE;
          end else begin
            lvl_next   = lvl + LVL_ONE;
            j_next     = NODE_FW'(1);
            state_next = S_BD_RD1;
          end
        end else begin
          j_next     = j + NODE_FW'(1);
          state_next = S_BD_RD1;
        end
      end

      // Query: read both depths and make a the deeper node.
      S_Q_RDA: begin
        dep_req.node = a;
        state_next   = S_Q_RDB;
      end
      S_Q_RDB: begin
        da_next      = dep_rdata;
        dep_req.node = b;
        state_next   = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (da < dep_rdata) begin
          a_next    = b;
          b_next    = a;
          diff_next = dep_rdata - da;
        end else begin
          diff_next = da - dep_rdata;
        end
        lvl_next   = LVL_LAST;
        state_next = S_Q_LIFT;
      end

      // Depth equalization, one level per pass from the top down.
      S_Q_LIFT: begin
        if (jump) begin
          anc_req.level = LVL_FW'(lvl);
          anc_req.node  = a;
          state_next    = S_Q_LIFTW;
        end else if (lvl == '0) begin
          state_next = S_Q_EQ;
        end else begin
          lvl_next = lvl_dec;
        end
      end
      S_Q_LIFTW: begin
        a_next = anc_rdata;
        if (lvl == '0) begin
          state_next = S_Q_EQ;
        end else begin
          lvl_next   = lvl_dec;
          state_next = S_Q_LIFT;
        end
      end
      S_Q_EQ: begin
        if (a == b) begin
          result_next = a;
          state_next  = S_DONE;
        end else begin
          lvl_next   = LVL_LAST;
          state_next = S_Q2_RA;
        end
      end

      // Joint lifting while the ancestors at a level differ. The stored depth of
      // the current node decides whether the level is tried at all.
      S_Q2_RA: begin
        anc_req.level = LVL_FW'(lvl);
        anc_req.node  = a;
        dep_req.node  = a;
        state_next    = S_Q2_RB;
      end
      S_Q2_RB: begin
        if (deep_enough) begin
          pa_next       = anc_rdata;
          anc_req.level = LVL_FW'(lvl);
          anc_req.node  = b;
          state_next    = S_Q2_UPD;
        end else if (lvl == '0) begin
          state_next = S_Q_FIN;
        end else begin
          lvl_next   = lvl_dec;
          state_next = S_Q2_RA;
        end
      end
      S_Q2_UPD: begin
        if (pa != anc_rdata) begin
          a_next = pa;
          b_next = anc_rdata;
        end
        if (lvl == '0) begin
          state_next = S_Q_FIN;
        end else begin
          lvl_next   = lvl_dec;
          state_next = S_Q2_RA;
        end
      end

      // The answer is the common parent.
      S_Q_FIN: begin
        anc_req.level = '0;
        anc_req.node  = a;
        state_next    = S_Q_RES;
      end
      S_Q_RES: begin
        result_next = anc_rdata;
        state_next  = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_data_next  = result;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // The level counter never leaves the table.
  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (32'(lvl) < LEVELS))
    else $error("level counter out of range");

  // Build writes go to levels above zero and nodes inside the sweep.
  a_build_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BD_WR) |-> ((j != '0) && (j <= last) && (lvl != '0)))
    else $error("build write outside the sweep");

  // A new result appears only from the hand-off state.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the hand-off state");

  // A query naming a bad node goes straight to the hand-off.
  a_bad_query: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && (cmd.command == CMD_QUERY) && !(ok_a && ok_b))
      |=> (state == S_DONE))
    else $error("rejected query did not return at once");

  // No command is taken while a table write is under way.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    anc_req.we |-> !cmd.ready)
    else $error("command accepted during a table write");

endmodule

`default_nettype wire

### design/lowest_common_ancestor_lifting.sv
// Top level of the binary-lifting lowest common ancestor engine.
`default_nettype none

// Lowest common ancestor engine over a tree rooted at node 1, one item at a time.
// A load item writes a parent link; a build fills levels 1 to LEVELS-1 for nodes 1
// to min(node_count, NODES-1), each entry with two reads of the level below and one
// write; a query equalizes depths, lifts both nodes jointly and then reads the
// common parent. Every ancestor lookup of a walk goes through the single port of
// the ancestor memory. A query naming node 0 or a node at or above NODES returns
// 0. The result sits in an output register, so the next item is taken while it
// waits. Both memories hold no reset state: the root's depth and its level-0 link
// are supplied by logic, and entries of nodes never loaded are undefined, so loads
// must come parents first and a build must precede queries.
module lowest_common_ancestor_lifting #(
  parameter int NODES  = lcal_pkg::NODES_DEFAULT,
  parameter int LEVELS = lcal_pkg::LEVELS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lcal_pkg::NODE_FW-1:0] cfg_wdata,
  lcal_cmd_if.sink                          cmd,
  lcal_rsp_if.source                        rsp
);
  import lcal_pkg::*;

  logic [NODE_FW-1:0] node_count;
  anc_req_t           anc_req;
  dep_req_t           dep_req;
  logic [NODE_FW-1:0] anc_rdata;
  logic [NODE_FW-1:0] dep_rdata;

  // Node count register; the host must write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_FW'(2);
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  lcal_ctrl #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .node_count (node_count),
    .cmd        (cmd),
    .rsp        (rsp),
    .anc_req    (anc_req),
    .anc_rdata  (anc_rdata),
    .dep_req    (dep_req),
    .dep_rdata  (dep_rdata)
  );

  lcal_anc_mem #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_anc_mem (
    .clk   (clk),
    .req   (anc_req),
    .rdata (anc_rdata)
  );

  lcal_dep_mem #(
    .NODES (NODES)
  ) u_dep_mem (
    .clk   (clk),
    .req   (dep_req),
    .rdata (dep_rdata)
  );

endmodule

`default_nettype wire

### bench/tb_lowest_common_ancestor_lifting.sv
// Self-checking testbench for the binary-lifting lowest common ancestor engine.
`timescale 1ns / 100ps

module tb_lowest_common_ancestor_lifting;
  import lcal_pkg::*;

  localparam int NODES  = NODES_DEFAULT;
  localparam int LEVELS = LEVELS_DEFAULT;

  // Command code 3 is unused by the block and must be dropped without a result.
  localparam logic [1:0] CMD_RSVD = 2'd3;

  // Amount of ordinary work in the random part, and the length of the receiver hold-off.
  localparam int WORK_TARGET = 1150;
  localparam int HOLD_CYCLES = 600;
  // Tail after a query or a load; a build lengthens it with the size of its sweep.
  localparam int TAIL_CYCLES = 100;
  // Watchdog in ns.
  localparam longint WATCHDOG_NS = 64'd12_000_000;

  // One row of the directed stimulus: either a node_count write or an item.
  typedef struct packed {
    logic               cfg;
    logic [1:0]         command;
    logic [NODE_FW-1:0] node_a;
    logic [NODE_FW-1:0] node_b;
    logic               typed;
    logic [NODE_FW-1:0] ancestor;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    // Right after reset: queries naming node 0, unused code, ignored loads.
    '{1'b0, CMD_QUERY, 16'd0,     16'd5,     1'b1, 16'd0},
    '{1'b0, CMD_QUERY, 16'hFFFF,  16'd0,     1'b1, 16'd0},
    '{1'b0, CMD_RSVD,  16'hFFFF,  16'hFFFF,  1'b0, 16'd0},
    '{1'b0, CMD_LOAD,  16'd1,     16'd1,     1'b0, 16'd0},
    '{1'b0, CMD_LOAD,  16'd0,     16'd1,     1'b0, 16'd0},
    // Smallest tree, node_count still at its reset value of two.
    '{1'b0, CMD_LOAD,  16'd2,     16'd1,     1'b0, 16'd0},
    '{1'b0, CMD_BUILD, 16'd0,     16'd0,     1'b0, 16'd0},
    '{1'b0, CMD_QUERY, 16'd2,     16'd1,     1'b1, 16'd1},
    '{1'b0, CMD_QUERY, 16'd2,     16'd2,     1'b1, 16'd2},
    // A small tree of six nodes.
    '{1'b1, CMD_LOAD,  16'd6,     16'd0,     1'b0, 16'd0},
    '{1'b0, CMD_LOAD,  16'd3,     16'd1,     1'b0, 16'd0},
    '{1'b0, CMD_LOAD,  16'd4,     16'd2,     1'b0, 16'd0},
    '{1'b0, CMD_LOAD,  16'd5,     16'd2,     1'b0, 16'd0},
    '{1'b0, CMD_LOAD,  16'd6,     16'd4,     1'b0, 16'd0},
    '{1'b0, CMD_BUILD, 16'hFFFF,  16'hFFFF,  1'b0, 16'd0},
    '{1'b0, CMD_QUERY, 16'd5,     16'd6,     1'b0, 16'd0},
    '{1'b0, CMD_QUERY, 16'd6,     16'd3,     1'b0, 16'd0},
    '{1'b0, CMD_QUERY, 16'd4,     16'd4,     1'b1, 16'd4},
    '{1'b0, CMD_QUERY, 16'd0,     16'hFFFF,  1'b1, 16'd0},
    // Relink without a rebuild, so the walk uses stale upper levels.
    '{1'b0, CMD_LOAD,  16'd6,     16'd5,     1'b0, 16'd0},
    '{1'b0, CMD_QUERY, 16'd6,     16'd4,     1'b0, 16'd0},
    // Highest node number as a child of the root.
    '{1'b0, CMD_LOAD,  16'hFFFF,  16'd1,     1'b0, 16'd0}
  };

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [NODE_FW-1:0]  cfg_wdata;

  lcal_cmd_if cmd_if ();
  lcal_rsp_if rsp_if ();

  lowest_common_ancestor_lifting #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd_if),
    .rsp      (rsp_if)
  );

  // Shadow of the tree: ancestor levels, depths and the node_count register.
  bit [NODE_FW-1:0] lift_tab [LEVELS][NODES];
  bit [NODE_FW-1:0] depth_tab [NODES];
  bit [NODE_FW-1:0] node_count_r;

  // Ancestors owed by the block, oldest first.
  logic [NODE_FW-1:0] ancestor_q [$];

  int  error_count;
  int  busy_tail;
  int  work_items;
  bit  quiet_run;
  bit  hold_request;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit node_good(int unsigned n);
    return n != 0 && n < NODES;
  endfunction

  // A parent link also sets the child's depth, saturating at the top.
  function automatic void tree_load(int unsigned a, int unsigned b);
    int unsigned d;
    if (node_good(a) && node_good(b) && a != ROOT_NODE) begin
      d = 32'(depth_tab[b]);
      lift_tab[0][a] = NODE_FW'(b);
      depth_tab[a] = (d >= 32'(DEPTH_MAX)) ? DEPTH_MAX : NODE_FW'(d + 1);
    end
  endfunction

  // Level i of a node is level i-1 of its level i-1 ancestor.
  function automatic void tree_build();
    int unsigned last;
    last = 32'(node_count_r);
    if (last >= NODES) last = NODES - 1;
    lift_tab[0][ROOT_NODE] = ROOT_NODE;
    for (int i = 1; i < LEVELS; i++) begin
      for (int unsigned j = 1; j <= last; j++) begin
        lift_tab[i][j] = lift_tab[i-1][lift_tab[i-1][j]];
      end
    end
  endfunction

  // Equalize depths by power-of-two jumps, then lift both while they differ.
  function automatic logic [NODE_FW-1:0] tree_lca(int unsigned a_in, int unsigned b_in);
    int unsigned a, b, t, diff, step, pa, pb;
    a = a_in;
    b = b_in;
    if (!node_good(a) || !node_good(b)) return '0;
    if (depth_tab[a] < depth_tab[b]) begin
      t = a;
      a = b;
      b = t;
    end
    diff = 32'(depth_tab[a]) - 32'(depth_tab[b]);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      step = 1 << i;
      if (diff >= step) begin
        diff -= step;
        a = 32'(lift_tab[i][a]);
      end
    end
    if (a == b) return a[NODE_FW-1:0];
    for (int i = LEVELS - 1; i >= 0; i--) begin
      step = 1 << i;
      if (32'(depth_tab[a]) >= step) begin
        pa = 32'(lift_tab[i][a]);
        pb = 32'(lift_tab[i][b]);
        if (pa != pb) begin
          a = pa;
          b = pb;
        end
      end
    end
    return lift_tab[0][a];
  endfunction

  // Offer one item with random gaps ahead of it; update the shadow once it is taken.
  task automatic send_item(logic [1:0] command, logic [NODE_FW-1:0] a,
                           logic [NODE_FW-1:0] b, bit typed, logic [NODE_FW-1:0] typed_val);
    int unsigned last;
    while (!quiet_run && $urandom_range(0, 99) < 24) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= command;
    cmd_if.node_a  <= a;
    cmd_if.node_b  <= b;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    busy_tail = TAIL_CYCLES;
    if (command == CMD_LOAD) begin
      tree_load(32'(a), 32'(b));
    end else if (command == CMD_BUILD) begin
      tree_build();
      last = 32'(node_count_r);
      if (last >= NODES) last = NODES - 1;
      busy_tail = 3 * (LEVELS - 1) * last + TAIL_CYCLES;
    end else if (command == CMD_QUERY) begin
      ancestor_q.insert(ancestor_q.size(), typed ? typed_val : tree_lca(32'(a), 32'(b)));
    end
  endtask

  // Stop offering and wait until every owed ancestor has come back.
  task automatic wait_for_results();
    cmd_if.valid <= 1'b0;
    while (ancestor_q.size() != 0) @(posedge clk);
  endtask

  // node_count is only written with the block idle, after any build has run out.
  task automatic write_node_count(logic [NODE_FW-1:0] value);
    wait_for_results();
    repeat (busy_tail) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_r = value;
  endtask

  // A query over the loaded tree, now and then naming node 0.
  task automatic send_query(int unsigned tree_n);
    logic [NODE_FW-1:0] a, b;
    a = NODE_FW'($urandom_range(1, tree_n));
    b = NODE_FW'($urandom_range(1, tree_n));
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 0) a = '0;
      else b = '0;
    end
    send_item(CMD_QUERY, a, b, 1'b0, '0);
    work_items++;
  endtask

  // Items the block drops or answers at once; loaded_max bounds the partners named.
  task automatic send_noise(int unsigned loaded_max);
    case ($urandom_range(0, 3))
      0: send_item(CMD_RSVD, NODE_FW'($urandom), NODE_FW'($urandom), 1'b0, '0);
      1: send_item(CMD_LOAD, ROOT_NODE, NODE_FW'($urandom_range(1, loaded_max)), 1'b0, '0);
      2: send_item(CMD_LOAD, '0, NODE_FW'($urandom_range(1, loaded_max)), 1'b0, '0);
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(CMD_QUERY, '0, NODE_FW'($urandom), 1'b0, '0);
        end else begin
          send_item(CMD_QUERY, NODE_FW'($urandom), '0, 1'b0, '0);
        end
      end
    endcase
  endtask

  // Result side: random back-pressure, a long hold-off on request, field check.
  initial begin : result_side
    int hold_left;
    logic [NODE_FW-1:0] want;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        if (ancestor_q.size() == 0) begin
          $error("ancestor: unexpected result, actual %0d", rsp_if.ancestor);
          error_count++;
        end else begin
          want = ancestor_q.pop_front();
          if (rsp_if.ancestor !== want) begin
            $error("ancestor: expected %0d, actual %0d", want, rsp_if.ancestor);
            error_count++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (quiet_run) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("lowest_common_ancestor_lifting verification failed");
    $finish;
  end

  // Stimulus: directed table, then random trees phase by phase.
  initial begin : stimulus
    int unsigned tree_n, parent, k, phase, shape;
    dir_row_t row;
    error_count    = 0;
    busy_tail      = 0;
    work_items     = 0;
    quiet_run      = 1'b0;
    hold_request   = 1'b0;
    lift_tab[0][ROOT_NODE] = ROOT_NODE;
    node_count_r   = 16'd2;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_LOAD;
    cmd_if.node_a  = '0;
    cmd_if.node_b  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TABLE[r];
      if (row.cfg) write_node_count(row.node_a);
      else send_item(row.command, row.node_a, row.node_b, row.typed, row.ancestor);
    end

    phase = 0;
    while (work_items < WORK_TARGET) begin
      // Mostly small trees; a few large ones keep the build cost bounded.
      case ($urandom_range(0, 19))
        0:       tree_n = $urandom_range(151, 400);
        1, 2, 3: tree_n = $urandom_range(41, 150);
        default: tree_n = $urandom_range(2, 40);
      endcase
      quiet_run = (phase == 5);
      write_node_count(NODE_FW'(tree_n));

      // Parents always come before children, in one of several shapes.
      shape = $urandom_range(0, 3);
      for (k = 2; k <= tree_n; k++) begin
        if ($urandom_range(0, 19) == 0) send_noise(k - 1);
        case (shape)
          0:       parent = $urandom_range(1, k - 1);
          1:       parent = k - 1;
          2:       parent = ROOT_NODE;
          default: parent = (k > 4) ? k - $urandom_range(1, 3) : 1;
        endcase
        send_item(CMD_LOAD, NODE_FW'(k), NODE_FW'(parent), 1'b0, '0);
        work_items++;
      end
      send_item(CMD_BUILD, NODE_FW'($urandom), NODE_FW'($urandom), 1'b0, '0);
      work_items++;

      // Once the receiver holds off while queries keep coming; once the sender drains first.
      if (phase == 2) hold_request = 1'b1;
      if (phase == 4) wait_for_results();
      repeat ($urandom_range(5, 30)) send_query(tree_n);

      // Relink a few nodes, query on the stale levels, maybe rebuild.
      if (tree_n > 2 && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(2, tree_n);
          send_item(CMD_LOAD, NODE_FW'(k), NODE_FW'($urandom_range(1, k - 1)), 1'b0, '0);
          work_items++;
        end
        repeat (5) send_query(tree_n);
        if ($urandom_range(0, 1) == 0) begin
          send_item(CMD_BUILD, NODE_FW'($urandom), NODE_FW'($urandom), 1'b0, '0);
          work_items++;
          repeat (5) send_query(tree_n);
        end
      end

      // Largest node_count, used by queries only.
      if (phase == 3) begin
        write_node_count(16'hFFFF);
        repeat (10) send_query(tree_n);
      end
      quiet_run = 1'b0;
      phase++;
    end

    wait_for_results();
    repeat (busy_tail) @(posedge clk);
    if (error_count == 0) begin
      $display("lowest_common_ancestor_lifting verification clean");
    end else begin
      $display("lowest_common_ancestor_lifting verification failed");
    end
    $finish;
  end

endmodule
